// ----- design/best_fit_block_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Best-fit block allocator assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BFBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bfba_pkg.sv -----
// ----------------------------------------------------------------------------
// Best-fit block allocator package
// Field widths, request codes and result status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfba_pkg;

    localparam int ADDR_W = 21;
    localparam int ACT_W  = 2;

    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REALLOC = 2'd2;

    localparam logic [ADDR_W-1:0] POOL_RESET = 21'd65536;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_ZERO     = 2'd2,
        ST_BAD_ADDR = 2'd3
    } status_t;

endpackage

`default_nettype wire

// ----- design/best_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// Best-fit block allocator
// Address-ordered block chain with best-fit alloc, split, forward coalesce.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir | handshake
//  in      | action, request_size, address             | in  | in_valid/in_ready
//  out     | result_address, status, moved, copy_bytes | out | out_valid/out_ready
//  cfg     | cfg_wdata (pool_size)                     | in  | cfg_we, no wait
//
//  One request at a time; each chain step is one read through the single
//  table read port. An alloc walks the whole chain; a free walks to its block
//  and then absorbs free successors; a moving realloc does the find, the alloc
//  walk and the free. A split adds a free-slot scan and two table writes.
//  After reset or a pool_size write, the S_INIT state rewrites the head entry.
//  A waiting result sits in the output register and stalls only the next one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "best_fit_block_allocator_defines.svh"

module best_fit_block_allocator #(
    parameter int MAX_BLOCKS   = 128,
    parameter int HEADER_BYTES = 24,
    parameter int MIN_BLOCK    = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [bfba_pkg::ADDR_W-1:0] cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [bfba_pkg::ACT_W-1:0]  action,
    input  wire logic [bfba_pkg::ADDR_W-1:0] request_size,
    input  wire logic [bfba_pkg::ADDR_W-1:0] address,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [bfba_pkg::ADDR_W-1:0]      result_address,
    output logic [1:0]                       status,
    output logic                             moved,
    output logic [bfba_pkg::ADDR_W-1:0]      copy_bytes
);

    import bfba_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int DW = 2 * ADDR_W + IW;
    localparam int NW = ADDR_W + 1;
    localparam int TW = ADDR_W + 2;

    localparam logic [ADDR_W-1:0] HDR  = ADDR_W'(HEADER_BYTES);
    localparam logic [TW-1:0]     HDRT = TW'(HEADER_BYTES);
    localparam logic [TW-1:0]     MINT = TW'(MIN_BLOCK);
    localparam logic [IW-1:0]     LAST = IW'(MAX_BLOCKS - 1);

    typedef enum logic [13:0] {
        S_INIT   = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_FD_RD  = 14'b00000000000100,
        S_FD_EV  = 14'b00000000001000,
        S_AL_RD  = 14'b00000000010000,
        S_AL_EV  = 14'b00000000100000,
        S_AL_END = 14'b00000001000000,
        S_SCAN   = 14'b00000010000000,
        S_SPLIT  = 14'b00000100000000,
        S_SPLIT2 = 14'b00001000000000,
        S_FR_RD  = 14'b00010000000000,
        S_FR_EV  = 14'b00100000000000,
        S_FR_EVN = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0]     pool_size_reg, pool_size_next;
    logic [MAX_BLOCKS-1:0] valid_reg, valid_next;
    logic [MAX_BLOCKS-1:0] free_reg, free_next;
    logic                  found_reg, found_next;
    logic                  move_reg, move_next;
    logic                  out_valid_reg, out_valid_next;

    logic [ACT_W-1:0]  act_reg, act_next;
    logic [ADDR_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [NW-1:0]     need_reg, need_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     best_reg, best_next;
    logic [IW-1:0]     best_succ_reg, best_succ_next;
    logic [ADDR_W-1:0] best_bytes_reg, best_bytes_next;
    logic [ADDR_W-1:0] best_start_reg, best_start_next;
    logic [IW-1:0]     slot_reg, slot_next;
    logic [ADDR_W-1:0] old_bytes_reg, old_bytes_next;
    logic [ADDR_W-1:0] cur_start_reg, cur_start_next;
    logic [ADDR_W-1:0] cur_bytes_reg, cur_bytes_next;
    logic [ADDR_W-1:0] res_reg, res_next;
    status_t           stat_reg, stat_next;
    logic              moved_reg, moved_next;
    logic [ADDR_W-1:0] copy_reg, copy_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    status_t           out_stat_reg, out_stat_next;
    logic              out_moved_reg, out_moved_next;
    logic [ADDR_W-1:0] out_copy_reg, out_copy_next;

    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [DW-1:0]     mem_wdata;
    logic [IW-1:0]     mem_raddr;
    logic [DW-1:0]     mem_rdata;

    logic [ADDR_W-1:0] rd_start;
    logic [ADDR_W-1:0] rd_bytes;
    logic [IW-1:0]     rd_succ;
    logic              rd_has_next;
    logic              best_has_next;
    logic              fits;
    logic [ADDR_W-1:0] merged_bytes;
    logic [IW-1:0]     merged_succ;

    bfba_table #(
        .DEPTH (MAX_BLOCKS),
        .AW    (IW),
        .DW    (DW)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_start = mem_rdata[ADDR_W-1:0];
    assign rd_bytes = mem_rdata[2*ADDR_W-1:ADDR_W];
    assign rd_succ  = mem_rdata[DW-1:2*ADDR_W];

    assign rd_has_next = (rd_succ != cur_reg) && (int'(rd_succ) < MAX_BLOCKS)
                         && valid_reg[rd_succ];
    assign best_has_next = (best_succ_reg != best_reg)
                           && (int'(best_succ_reg) < MAX_BLOCKS)
                           && valid_reg[best_succ_reg];
    assign fits = valid_reg[cur_reg] && free_reg[cur_reg]
                  && (NW'(rd_bytes) >= need_reg)
                  && (!found_reg || (rd_bytes < best_bytes_reg));
    assign merged_bytes = cur_bytes_reg + HDR + rd_bytes;
    assign merged_succ  = rd_has_next ? rd_succ : idx_reg;

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign result_address = out_addr_reg;
    assign status         = out_stat_reg;
    assign moved          = out_moved_reg;
    assign copy_bytes     = out_copy_reg;

    always_comb
    begin
        state_next      = state_reg;
        pool_size_next  = pool_size_reg;
        valid_next      = valid_reg;
        free_next       = free_reg;
        found_next      = found_reg;
        move_next       = move_reg;
        out_valid_next  = out_valid_reg;
        act_next        = act_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        need_next       = need_reg;
        cur_next        = cur_reg;
        idx_next        = idx_reg;
        best_next       = best_reg;
        best_succ_next  = best_succ_reg;
        best_bytes_next = best_bytes_reg;
        best_start_next = best_start_reg;
        slot_next       = slot_reg;
        old_bytes_next  = old_bytes_reg;
        cur_start_next  = cur_start_reg;
        cur_bytes_next  = cur_bytes_reg;
        res_next        = res_reg;
        stat_next       = stat_reg;
        moved_next      = moved_reg;
        copy_next       = copy_reg;
        out_addr_next   = out_addr_reg;
        out_stat_next   = out_stat_reg;
        out_moved_next  = out_moved_reg;
        out_copy_next   = out_copy_reg;
        mem_we          = 1'b0;
        mem_waddr       = cur_reg;
        mem_wdata       = '0;
        mem_raddr       = cur_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = {IW'(0),
                              (pool_size_reg > HDR) ? (pool_size_reg - HDR) : ADDR_W'(0),
                              ADDR_W'(0)};
                valid_next = MAX_BLOCKS'(1);
                free_next  = MAX_BLOCKS'(1);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action;
                    size_next  = request_size;
                    addr_next  = address;
                    need_next  = (NW'(request_size) + NW'(7)) & ~NW'(7);
                    res_next   = '0;
                    stat_next  = ST_OK;
                    moved_next = 1'b0;
                    copy_next  = '0;
                    move_next  = 1'b0;
                    state_next = S_DONE;
                    case (action)
                        ACT_ALLOC:
                        begin
                            if (request_size == '0)
                                stat_next = ST_ZERO;
                            else
                                state_next = S_AL_RD;
                        end
                        ACT_FREE:
                        begin
                            if (address != '0)
                                state_next = S_FD_RD;
                        end
                        ACT_REALLOC:
                        begin
                            if (address != '0)
                                state_next = S_FD_RD;
                            else if (request_size == '0)
                                stat_next = ST_ZERO;
                            else
                                state_next = S_AL_RD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FD_RD:
            begin
                mem_raddr  = '0;
                cur_next   = '0;
                state_next = S_FD_EV;
            end
            S_FD_EV:
            begin
                if (valid_reg[cur_reg] && !free_reg[cur_reg]
                    && ((rd_start + HDR) == addr_reg))
                begin
                    idx_next = cur_reg;
                    if (act_reg == ACT_FREE || size_reg == '0)
                    begin
                        state_next = S_FR_RD;
                    end
                    else if (rd_bytes >= size_reg)
                    begin
                        res_next   = addr_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        old_bytes_next = rd_bytes;
                        move_next      = 1'b1;
                        state_next     = S_AL_RD;
                    end
                end
                else if (rd_has_next)
                begin
                    mem_raddr = rd_succ;
                    cur_next  = rd_succ;
                end
                else
                begin
                    stat_next  = ST_BAD_ADDR;
                    state_next = S_DONE;
                end
            end
            S_AL_RD:
            begin
                mem_raddr  = '0;
                cur_next   = '0;
                found_next = 1'b0;
                state_next = S_AL_EV;
            end
            S_AL_EV:
            begin
                if (fits)
                begin
                    found_next      = 1'b1;
                    best_next       = cur_reg;
                    best_bytes_next = rd_bytes;
                    best_start_next = rd_start;
                    best_succ_next  = rd_succ;
                end
                if (rd_has_next)
                begin
                    mem_raddr = rd_succ;
                    cur_next  = rd_succ;
                end
                else
                begin
                    state_next = S_AL_END;
                end
            end
            S_AL_END:
            begin
                if (!found_reg)
                begin
                    stat_next  = ST_NO_FIT;
                    state_next = S_DONE;
                end
                else
                begin
                    free_next[best_reg] = 1'b0;
                    if (TW'(best_bytes_reg) >= TW'(need_reg) + HDRT + MINT)
                    begin
                        slot_next  = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        res_next   = best_start_reg + HDR;
                        state_next = move_reg ? S_FR_RD : S_DONE;
                        moved_next = move_reg;
                        copy_next  = move_reg ? old_bytes_reg : ADDR_W'(0);
                    end
                end
            end
            S_SCAN:
            begin
                if (!valid_reg[slot_reg])
                begin
                    state_next = S_SPLIT;
                end
                else if (slot_reg == LAST)
                begin
                    res_next   = best_start_reg + HDR;
                    state_next = move_reg ? S_FR_RD : S_DONE;
                    moved_next = move_reg;
                    copy_next  = move_reg ? old_bytes_reg : ADDR_W'(0);
                end
                else
                begin
                    slot_next = slot_reg + IW'(1);
                end
            end
            S_SPLIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_reg;
                mem_wdata = {best_has_next ? best_succ_reg : slot_reg,
                             ADDR_W'(TW'(best_bytes_reg) - TW'(need_reg) - HDRT),
                             ADDR_W'(TW'(best_start_reg) + HDRT + TW'(need_reg))};
                valid_next[slot_reg] = 1'b1;
                free_next[slot_reg]  = 1'b1;
                state_next = S_SPLIT2;
            end
            S_SPLIT2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = best_reg;
                mem_wdata  = {slot_reg, ADDR_W'(need_reg), best_start_reg};
                res_next   = best_start_reg + HDR;
                state_next = move_reg ? S_FR_RD : S_DONE;
                moved_next = move_reg;
                copy_next  = move_reg ? old_bytes_reg : ADDR_W'(0);
            end
            S_FR_RD:
            begin
                mem_raddr          = idx_reg;
                cur_next           = idx_reg;
                free_next[idx_reg] = 1'b1;
                state_next         = S_FR_EV;
            end
            S_FR_EV:
            begin
                cur_start_next = rd_start;
                cur_bytes_next = rd_bytes;
                if (rd_has_next && free_reg[rd_succ])
                begin
                    mem_raddr  = rd_succ;
                    cur_next   = rd_succ;
                    state_next = S_FR_EVN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FR_EVN:
            begin
                // absorb entry cur into idx
                mem_we              = 1'b1;
                mem_waddr           = idx_reg;
                mem_wdata           = {merged_succ, merged_bytes, cur_start_reg};
                cur_bytes_next      = merged_bytes;
                valid_next[cur_reg] = 1'b0;
                free_next[cur_reg]  = 1'b0;
                if (rd_has_next && free_reg[rd_succ])
                begin
                    mem_raddr = rd_succ;
                    cur_next  = rd_succ;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_reg;
                    out_stat_next  = stat_reg;
                    out_moved_next = moved_reg;
                    out_copy_next  = copy_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        if (cfg_we)
        begin
            pool_size_next = cfg_wdata;
            state_next     = S_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            pool_size_reg <= POOL_RESET;
            valid_reg     <= '0;
            free_reg      <= '0;
            found_reg     <= 1'b0;
            move_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pool_size_reg <= pool_size_next;
            valid_reg     <= valid_next;
            free_reg      <= free_next;
            found_reg     <= found_next;
            move_reg      <= move_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        need_reg       <= need_next;
        cur_reg        <= cur_next;
        idx_reg        <= idx_next;
        best_reg       <= best_next;
        best_succ_reg  <= best_succ_next;
        best_bytes_reg <= best_bytes_next;
        best_start_reg <= best_start_next;
        slot_reg       <= slot_next;
        old_bytes_reg  <= old_bytes_next;
        cur_start_reg  <= cur_start_next;
        cur_bytes_reg  <= cur_bytes_next;
        res_reg        <= res_next;
        stat_reg       <= stat_next;
        moved_reg      <= moved_next;
        copy_reg       <= copy_next;
        out_addr_reg   <= out_addr_next;
        out_stat_reg   <= out_stat_next;
        out_moved_reg  <= out_moved_next;
        out_copy_reg   <= out_copy_next;
    end

    `BFBA_ASSERT_IMP(a_head_valid, state_reg != S_INIT, valid_reg[0], "head entry not valid")
    `BFBA_ASSERT_NXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "ready after beat")
    `BFBA_ASSERT_IMP(a_zero_size, out_valid && status == ST_ZERO, result_address == '0 && !moved, "zero size with address")
    `BFBA_ASSERT_IMP(a_moved_ok, out_valid && moved, status == ST_OK, "moved without ok")

endmodule

`default_nettype wire

// ----- design/bfba_table.sv -----
// ----------------------------------------------------------------------------
// Block table memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfba_table #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 49
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit block allocator testbench
// Random and directed alloc/free/realloc requests with random gaps on both
// channels. A scoreboard keeps its own copy of the block table, predicts each
// result and checks results in order. The pool size is changed between phases.
// ----------------------------------------------------------------------------

module tb_top;

    import bfba_pkg::*;

    localparam int NBLK      = 128;
    localparam int HDR       = 24;
    localparam int MINB      = 16;
    localparam int MASK      = 32'h1F_FFFF;
    localparam int IDLE_MAX  = 20000;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        status_t           st;
        logic              mv;
        logic [ADDR_W-1:0] copy;
    } grant_t;

    class alloc_scoreboard;
        int unsigned bstart [NBLK];
        int unsigned bbytes [NBLK];
        bit          bfree  [NBLK];
        bit          bvalid [NBLK];
        int unsigned succ   [NBLK];
        grant_t      pending_grants[$];
        int          errors;

        function void set_pool(int unsigned pool);
            for (int k = 0; k < NBLK; k++) begin
                bstart[k] = 0; bbytes[k] = 0; bfree[k] = 0; bvalid[k] = 0; succ[k] = 0;
            end
            bbytes[0] = pool > HDR ? pool - HDR : 0;
            bfree[0]  = 1;
            bvalid[0] = 1;
        endfunction

        function bit linked(int unsigned i);
            return succ[i] != i && succ[i] < NBLK && bvalid[succ[i]];
        endfunction

        function bit lookup(int unsigned a, output int unsigned idx);
            int unsigned i;
            i = 0;
            idx = 0;
            for (int s = 0; s < NBLK; s++) begin
                if (bvalid[i] && !bfree[i] && ((bstart[i] + HDR) & MASK) == a) begin
                    idx = i;
                    return 1;
                end
                if (!linked(i)) break;
                i = succ[i];
            end
            return 0;
        endfunction

        function status_t grant(int unsigned size, output int unsigned a);
            int unsigned need, i, best, s;
            bit found;
            a = 0; i = 0; best = 0; found = 0;
            if (size == 0) return ST_ZERO;
            need = (size + 7) & ~32'd7;
            for (int k = 0; k < NBLK; k++) begin
                if (bvalid[i] && bfree[i] && bbytes[i] >= need &&
                    (!found || bbytes[i] < bbytes[best])) begin
                    best = i;
                    found = 1;
                end
                if (!linked(i)) break;
                i = succ[i];
            end
            if (!found) return ST_NO_FIT;
            bfree[best] = 0;
            if (bbytes[best] >= need + HDR + MINB) begin
                for (s = 0; s < NBLK; s++)
                    if (!bvalid[s]) break;
                if (s < NBLK) begin
                    bvalid[s] = 1;
                    bfree[s]  = 1;
                    bstart[s] = (bstart[best] + HDR + need) & MASK;
                    bbytes[s] = bbytes[best] - need - HDR;
                    succ[s]   = linked(best) ? succ[best] : s;
                    succ[best] = s;
                    bbytes[best] = need;
                end
            end
            a = (bstart[best] + HDR) & MASK;
            return ST_OK;
        endfunction

        function void release_blk(int unsigned idx);
            int unsigned n;
            bfree[idx] = 1;
            for (int s = 0; s < NBLK && linked(idx); s++) begin
                n = succ[idx];
                if (!bfree[n]) break;
                bbytes[idx] = (bbytes[idx] + HDR + bbytes[n]) & MASK;
                succ[idx] = linked(n) ? succ[n] : idx;
                bvalid[n] = 0;
                bfree[n]  = 0;
            end
        endfunction

        // random allocated payload offset, 0 when none
        function int unsigned pick_live();
            int unsigned live[$];
            for (int k = 0; k < NBLK; k++)
                if (bvalid[k] && !bfree[k]) live.push_back((bstart[k] + HDR) & MASK);
            if (live.size() == 0) return 0;
            return live[$urandom_range(0, live.size() - 1)];
        endfunction

        function void note_request(logic [1:0] act, int unsigned sz, int unsigned ad);
            grant_t g;
            int unsigned idx, old, a;
            g.addr = 0; g.st = ST_OK; g.mv = 0; g.copy = 0;
            a = 0; idx = 0;
            if (act == ACT_ALLOC) begin
                g.st = grant(sz, a);
            end else if (act == ACT_FREE) begin
                if (ad != 0) begin
                    if (lookup(ad, idx)) release_blk(idx);
                    else g.st = ST_BAD_ADDR;
                end
            end else if (act == ACT_REALLOC) begin
                if (ad == 0) begin
                    g.st = grant(sz, a);
                end else if (!lookup(ad, idx)) begin
                    g.st = ST_BAD_ADDR;
                end else if (sz == 0) begin
                    release_blk(idx);
                end else if (bbytes[idx] >= sz) begin
                    a = ad;
                end else begin
                    old = bbytes[idx];
                    g.st = grant(sz, a);
                    if (g.st == ST_OK) begin
                        release_blk(idx);
                        g.mv = 1;
                        g.copy = old & MASK;
                    end
                end
            end
            g.addr = a & MASK;
            pending_grants.push_back(g);
        endfunction

        function void check_result(logic [ADDR_W-1:0] ra, logic [1:0] st,
                                   logic mv, logic [ADDR_W-1:0] cb);
            grant_t g;
            if (pending_grants.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat: addr=%0d status=%0d", ra, st);
                return;
            end
            g = pending_grants.pop_front();
            if (ra !== g.addr || st !== g.st || mv !== g.mv || cb !== g.copy) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp addr=%0d st=%0d mv=%0d copy=%0d got %0d %0d %0d %0d",
                             g.addr, g.st, g.mv, g.copy, ra, st, mv, cb);
            end
        endfunction
    endclass

    logic              clk = 0;
    logic              rst_n = 0;
    logic              cfg_we = 0;
    logic [ADDR_W-1:0] cfg_wdata = '0;
    logic              in_valid = 0;
    logic              in_ready;
    logic [ACT_W-1:0]  action = '0;
    logic [ADDR_W-1:0] request_size = '0;
    logic [ADDR_W-1:0] address = '0;
    logic              out_valid;
    logic              out_ready = 0;
    logic [ADDR_W-1:0] result_address;
    logic [1:0]        status;
    logic              moved;
    logic [ADDR_W-1:0] copy_bytes;

    alloc_scoreboard sb = new();
    int unsigned     cur_pool = 65536;
    int              idle_cycles = 0;

    best_fit_block_allocator u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .request_size(request_size), .address(address),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_address(result_address), .status(status),
        .moved(moved), .copy_bytes(copy_bytes)
    );

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    function int unsigned draw_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    task automatic send(logic [1:0] act, int unsigned sz, int unsigned ad);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1;
        action       <= act;
        request_size <= sz[ADDR_W-1:0];
        address      <= ad[ADDR_W-1:0];
        do @(posedge clk); while (!in_ready);
        sb.note_request(act, sz & MASK, ad & MASK);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending_grants.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_pool(int unsigned pool);
        drain();
        cfg_we    <= 1;
        cfg_wdata <= pool[ADDR_W-1:0];
        @(posedge clk);
        cfg_we <= 0;
        sb.set_pool(pool);
        cur_pool = pool;
        repeat (4) @(posedge clk);
    endtask

    task automatic send_random(int count, int unsigned size_cap);
        int unsigned sel, sz, ad;
        logic [1:0] act;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) sz = $urandom_range(1, size_cap);
            else if (sel < 85) sz = $urandom_range(1, cur_pool / 3 + 1);
            else if (sel < 90) sz = 0;
            else sz = $urandom() & MASK;
            sel = $urandom_range(0, 99);
            ad = sb.pick_live();
            if (sel < 45) begin
                act = ACT_ALLOC;
                ad = $urandom() & MASK;
            end else if (sel < 70) act = ACT_FREE;
            else if (sel < 90) act = ACT_REALLOC;
            else begin
                act = 2'($urandom_range(0, 3));
                ad = ($urandom_range(0, 1) == 1) ? ($urandom() & MASK) : 0;
            end
            send(act, sz, ad);
        end
    endtask

    always
    begin
        int unsigned stall;
        stall = draw_gap();
        if (stall > 0) begin
            out_ready <= 0;
            repeat (stall) @(posedge clk);
        end
        out_ready <= 1;
        do @(posedge clk); while (!(out_valid && rst_n));
        sb.check_result(result_address, status, moved, copy_bytes);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned a;
        sb.set_pool(65536);
        repeat (9) @(posedge clk);
        rst_n <= 1;
        repeat (4) @(posedge clk);

        send(ACT_ALLOC, 0, 0);
        send(ACT_ALLOC, 1, 0);
        send(ACT_ALLOC, 8, 0);
        send(ACT_ALLOC, 100, 0);
        send(ACT_ALLOC, MASK, MASK);
        send(ACT_FREE, 0, 0);
        send(ACT_FREE, 7, 0);
        send(ACT_FREE, MASK, MASK);
        send(ACT_REALLOC, 40, 0);
        a = sb.pick_live();
        send(ACT_REALLOC, 4, a);
        a = sb.pick_live();
        send(ACT_REALLOC, 500, a);
        a = sb.pick_live();
        send(ACT_REALLOC, 1000000, a);
        a = sb.pick_live();
        send(ACT_REALLOC, 0, a);
        send(ACT_REALLOC, 8, 12345);
        send(2'd3, MASK, MASK);
        a = sb.pick_live();
        send(ACT_FREE, 0, a);
        send(ACT_ALLOC, 65536 - 24, 0);
        send(ACT_ALLOC, 65512, 0);
        send_random(60, 64);

        set_pool(64);
        send(ACT_ALLOC, 40, 0);
        send(ACT_ALLOC, 8, 0);
        send_random(15, 48);

        set_pool(1048576);
        for (int n = 0; n < 135; n++) send(ACT_ALLOC, $urandom_range(1, 16), 0);
        send_random(60, 32);

        set_pool(2048);
        send_random(60, 128);

        set_pool(300000);
        send_random(70, 256);

        drain();
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/bfba_pkg.sv
design/bfba_table.sv
design/best_fit_block_allocator.sv
bench/tb_top.sv
